[src/skto_pkg.sv]
// skto_pkg: shared types and constants for the sorted key table.
// No dependencies; imported by skto_table and sorted_key_table_open_top.
`default_nettype none
package skto_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int KEY_W           = 64;
    localparam int LOC_W           = 32;
    localparam int SLOT_W          = 6;
    localparam int STATUS_W        = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_FOUND    = 2'd0;
    localparam t_status ST_INSERTED = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_SHIFT
    } t_state;

endpackage
`default_nettype wire

[src/skto_table.sv]
// skto_table: single-write, single-read synchronous entry memory with registered read data.
// Uses skto_pkg for default sizes.
`default_nettype none
module skto_table
    import skto_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int WIDTH = KEY_BITS_DEF + LOC_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wa,
    input  wire logic [WIDTH-1:0]         i_wd,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_ra,
    output logic      [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end

endmodule
`default_nettype wire

[src/sorted_key_table_open_top.sv]
// sorted_key_table_open_top: sorted key table with binary-search lookup-or-insert.
// Search: each probe is a memory read then a compare, at most floor(log2(entry_count))+1 probes.
// A miss then either reports a full table or inserts: entries at and above the slot are shifted up
// by one, then the new entry is written at the slot. o_valid rises as busy drops, when the next
// request can already be accepted; requests are handled one at a time.
// Synchronous active-low reset empties the table; memory contents are left undefined.
`default_nettype none
module sorted_key_table_open_top
    import skto_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [LOC_W-1:0]  i_new_location,
    output logic                   o_valid,
    output logic [STATUS_W-1:0]    o_status,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [LOC_W-1:0]       o_location
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int DW = KEY_BITS + LOC_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    t_state r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_mid, n_mid;
    logic [AW-1:0]       r_wa, n_wa;
    logic                r_pend, n_pend;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [LOC_W-1:0]    r_loc_in, n_loc_in;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [LOC_W-1:0]    r_loc, n_loc;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [DW-1:0]       mem_wd, mem_rd;
    logic [KEY_BITS-1:0] probe_key;
    logic [LOC_W-1:0]    probe_loc;
    logic [CW-1:0]       mid_full;
    logic [EW-1:0]       mid_ext, lo_ext;

    skto_table #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DW)
    ) u_table (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    assign probe_key = mem_rd[DW-1:LOC_W];
    assign probe_loc = mem_rd[LOC_W-1:0];
    assign mid_full  = r_lo + ((r_hi - r_lo) >> 1);
    assign mid_ext   = EW'(r_mid);
    assign lo_ext    = EW'(r_lo);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_ptr    = r_ptr;
        n_mid    = r_mid;
        n_wa     = r_wa;
        n_pend   = 1'b0;
        n_key    = r_key;
        n_loc_in = r_loc_in;
        n_valid  = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        n_loc    = r_loc;
        mem_we   = 1'b0;
        mem_wa   = r_wa;
        mem_wd   = mem_rd;
        mem_re   = 1'b0;
        mem_ra   = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key    = i_key[KEY_BITS-1:0];
                    n_loc_in = i_new_location;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    mem_re  = 1'b1;
                    mem_ra  = mid_full[AW-1:0];
                    n_mid   = mid_full[AW-1:0];
                    n_state = S_CMP;
                end else if (r_count >= MAX_CNT) begin
                    n_valid  = 1'b1;
                    n_status = ST_FULL;
                    n_slot   = '0;
                    n_loc    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = r_count;
                    n_state = S_SHIFT;
                end
            end
            S_CMP: begin
                if (probe_key == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_FOUND;
                    n_slot   = mid_ext[SLOT_W-1:0];
                    n_loc    = probe_loc;
                    n_state  = S_IDLE;
                end else if (probe_key < r_key) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = S_SEARCH;
                end else begin
                    n_hi    = CW'(r_mid);
                    n_state = S_SEARCH;
                end
            end
            S_SHIFT: begin
                // read entry ptr-1 now, write it to ptr next cycle
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa;
                    mem_wd = mem_rd;
                end
                if (r_ptr > r_lo) begin
                    mem_re = 1'b1;
                    mem_ra = AW'(r_ptr - CW'(1));
                    n_ptr  = r_ptr - CW'(1);
                    n_wa   = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    mem_we   = 1'b1;
                    mem_wa   = r_lo[AW-1:0];
                    mem_wd   = {r_key, r_loc_in};
                    n_count  = r_count + CW'(1);
                    n_valid  = 1'b1;
                    n_status = ST_INSERTED;
                    n_slot   = lo_ext[SLOT_W-1:0];
                    n_loc    = r_loc_in;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ptr    <= n_ptr;
        r_mid    <= n_mid;
        r_wa     <= n_wa;
        r_key    <= n_key;
        r_loc_in <= n_loc_in;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_loc    <= n_loc;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_slot     = r_slot;
    assign o_location = r_loc;

endmodule
`default_nettype wire
